// ===== rtl/srts_pkg.sv =====
// Package for the sorted record table search block: request and result
// structs, command and status codes, and the sequencer state type. No dependencies.
`default_nettype none
package srts_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 1024;
    localparam int POS_W = 10;
    localparam int CNT_W = 11;
    localparam int KEY_W = 64;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_SORT   = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_READ   = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]       command;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] prev_word;
        logic [KEY_W-1:0] next_word;
        logic [POS_W-1:0] position;
    } request_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [POS_W-1:0] found_position;
        logic [CNT_W-1:0] entry_count;
        logic [KEY_W-1:0] out_key;
        logic [KEY_W-1:0] out_prev;
        logic [KEY_W-1:0] out_next;
    } result_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] prev_word;
        logic [KEY_W-1:0] next_word;
    } record_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_WAIT,
        S_RD_DONE,
        S_FIND_RD,
        S_FIND_CMP,
        S_PASS_INIT,
        S_RUN_INIT,
        S_MRG_RD,
        S_MRG_CMP,
        S_CPY_RD,
        S_CPY_WR,
        S_RUN_NEXT,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

// ===== rtl/sorted_record_table_search.sv =====
// Sorted record table search: a sequencer over one record memory, a merge
// scratch memory and key comparators. Depends on srts_pkg and srts_store.
//
// A request is taken when start is high and busy is low; its single result
// appears for one cycle with done high and cannot be stalled. A sort makes
// ceil(log2 N) merge passes; each merge step reads both run heads through the
// single table port and compares them, writes the chosen record to scratch, and
// each merged run is then read and copied back. No clearing pass is needed
// after reset.
`default_nettype none
module sorted_record_table_search
    import srts_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire request_t request,
    output logic          done,
    output result_t       result
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int N_W = IDX_W + 2;

    state_t state_reg, state_next;
    logic [N_W-1:0] count_reg, count_next;
    request_t req_reg, req_next;
    logic [N_W-1:0] l_reg, l_next, r_reg, r_next, m_reg, m_next;
    logic [N_W-1:0] w_reg, w_next, lo_reg, lo_next, mid_reg, mid_next;
    logic [N_W-1:0] hi_reg, hi_next, i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [KEY_W-1:0] ki_reg, ki_next;
    record_t ri_reg, ri_next;
    logic phase_reg, phase_next;
    result_t res_reg, res_next;
    logic done_reg, done_next;

    logic tab_we, scr_we;
    logic [IDX_W-1:0] tab_waddr, tab_raddr, scr_waddr, scr_raddr;
    record_t tab_wdata, tab_rdata, scr_wdata, scr_rdata;
    logic [N_W:0] mid_sum;
    logic take_left;

    srts_store #(.TABLE_DEPTH(TABLE_DEPTH), .IDX_W(IDX_W)) u_store (
        .clk(clk), .tab_we(tab_we), .tab_waddr(tab_waddr), .tab_wdata(tab_wdata),
        .tab_raddr(tab_raddr), .tab_rdata(tab_rdata), .scr_we(scr_we),
        .scr_waddr(scr_waddr), .scr_wdata(scr_wdata), .scr_raddr(scr_raddr),
        .scr_rdata(scr_rdata)
    );

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign result = res_reg;
    assign mid_sum = {1'b0, lo_reg} + {1'b0, w_reg};

    // The merge comparator: left run wins ties to keep the sort stable.
    assign take_left = (j_reg >= hi_reg) ||
                       ((i_reg < mid_reg) && (ki_reg <= tab_rdata.key));

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        req_reg <= req_next;   l_reg <= l_next;     r_reg <= r_next;
        m_reg <= m_next;       w_reg <= w_next;     lo_reg <= lo_next;
        mid_reg <= mid_next;   hi_reg <= hi_next;   i_reg <= i_next;
        j_reg <= j_next;       k_reg <= k_next;     ki_reg <= ki_next;
        ri_reg <= ri_next;     phase_reg <= phase_next;
        res_reg <= res_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (request.command)
                        CMD_APPEND: state_next = S_DONE;
                        CMD_SORT:   state_next = S_PASS_INIT;
                        CMD_FIND:   state_next = S_FIND_RD;
                        default:    state_next = S_RD_WAIT;
                    endcase
                end
            end
            S_RD_WAIT:   state_next = S_RD_DONE;
            S_RD_DONE:   state_next = S_IDLE;
            S_FIND_RD:
            begin
                if ($signed({1'b0, l_reg}) > $signed({r_reg[N_W-1], r_reg}))
                    state_next = S_DONE;
                else
                    state_next = S_FIND_CMP;
            end
            S_FIND_CMP:
            begin
                if (tab_rdata.key == req_reg.key)
                    state_next = S_IDLE;
                else
                    state_next = S_FIND_RD;
            end
            S_PASS_INIT:
                state_next = (w_reg < count_reg) ? S_RUN_INIT : S_DONE;
            S_RUN_INIT:
                state_next = (mid_sum < {1'b0, count_reg}) ? S_MRG_RD : S_PASS_INIT;
            S_MRG_RD:    state_next = S_MRG_CMP;
            S_MRG_CMP:
            begin
                if (phase_reg && (k_reg + 1'b1 == hi_reg - lo_reg))
                    state_next = S_CPY_RD;
                else
                    state_next = S_MRG_RD;
            end
            S_CPY_RD:    state_next = S_CPY_WR;
            S_CPY_WR:
                state_next = (k_reg + 1'b1 == hi_reg - lo_reg) ? S_RUN_NEXT : S_CPY_RD;
            S_RUN_NEXT:  state_next = S_RUN_INIT;
            S_DONE:      state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // Outputs and datapath.
    always_comb
    begin
        count_next = count_reg;  req_next = req_reg;
        l_next = l_reg;   r_next = r_reg;   m_next = m_reg;
        w_next = w_reg;   lo_next = lo_reg; mid_next = mid_reg; hi_next = hi_reg;
        i_next = i_reg;   j_next = j_reg;   k_next = k_reg;
        ki_next = ki_reg; ri_next = ri_reg; phase_next = phase_reg;
        res_next = res_reg;  done_next = 1'b0;
        tab_we = 1'b0;  tab_waddr = count_reg[IDX_W-1:0];
        tab_wdata = '{key: request.key, prev_word: request.prev_word,
                      next_word: request.next_word};
        tab_raddr = IDX_W'(req_reg.position);
        scr_we = 1'b0;  scr_waddr = k_reg[IDX_W-1:0];  scr_wdata = ri_reg;
        scr_raddr = k_reg[IDX_W-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next = request;
                    l_next = '0;
                    r_next = count_reg - 1'b1;
                    w_next = {{(N_W-1){1'b0}}, 1'b1};
                    lo_next = '0;
                    res_next = '0;
                    res_next.entry_count = CNT_W'(count_reg);
                    if (request.command == CMD_APPEND)
                    begin
                        if (count_reg >= N_W'(TABLE_DEPTH))
                        begin
                            res_next.status = ST_FULL;
                        end
                        else
                        begin
                            tab_we = 1'b1;
                            res_next.found_position = POS_W'(count_reg);
                            res_next.out_key  = request.key;
                            res_next.out_prev = request.prev_word;
                            res_next.out_next = request.next_word;
                            res_next.entry_count = CNT_W'(count_reg + 1'b1);
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
            end
            S_RD_DONE:
            begin
                done_next = 1'b1;
                if ({{N_W{1'b0}}, req_reg.position} >= {{POS_W{1'b0}}, count_reg})
                begin
                    res_next.status = ST_RANGE;
                end
                else
                begin
                    res_next.found_position = req_reg.position;
                    res_next.out_key  = tab_rdata.key;
                    res_next.out_prev = tab_rdata.prev_word;
                    res_next.out_next = tab_rdata.next_word;
                end
            end
            S_FIND_RD:
            begin
                m_next = N_W'(({1'b0, l_reg} + {r_reg[N_W-1], r_reg}) >> 1);
                tab_raddr = m_next[IDX_W-1:0];
                if ($signed({1'b0, l_reg}) > $signed({r_reg[N_W-1], r_reg}))
                    res_next.status = ST_NOT_FOUND;
            end
            S_FIND_CMP:
            begin
                if (tab_rdata.key == req_reg.key)
                begin
                    done_next = 1'b1;
                    res_next.found_position = POS_W'(m_reg);
                    res_next.out_key  = tab_rdata.key;
                    res_next.out_prev = tab_rdata.prev_word;
                    res_next.out_next = tab_rdata.next_word;
                end
                else if (tab_rdata.key < req_reg.key)
                    l_next = m_reg + 1'b1;
                else
                    r_next = m_reg - 1'b1;
            end
            S_PASS_INIT:
            begin
                lo_next = '0;
            end
            S_RUN_INIT:
            begin
                if (mid_sum < {1'b0, count_reg})
                begin
                    mid_next = N_W'(mid_sum);
                    hi_next = (mid_sum + {1'b0, w_reg} < {1'b0, count_reg}) ?
                              N_W'(mid_sum + {1'b0, w_reg}) : count_reg;
                    i_next = lo_reg;  j_next = N_W'(mid_sum);
                    k_next = '0;      phase_next = 1'b0;
                end
                else
                begin
                    w_next = w_reg << 1;
                end
            end
            S_MRG_RD:
            begin
                // Even phase reads the left head, odd phase the right head.
                tab_raddr = phase_reg ? j_reg[IDX_W-1:0] : i_reg[IDX_W-1:0];
            end
            S_MRG_CMP:
            begin
                if (!phase_reg)
                begin
                    ki_next = tab_rdata.key;
                    ri_next = tab_rdata;
                    phase_next = 1'b1;
                end
                else
                begin
                    scr_we = 1'b1;
                    scr_wdata = take_left ? ri_reg : tab_rdata;
                    k_next = k_reg + 1'b1;
                    if (take_left) i_next = i_reg + 1'b1;
                    else j_next = j_reg + 1'b1;
                    phase_next = 1'b0;
                    if (k_reg + 1'b1 == hi_reg - lo_reg)
                        k_next = '0;
                end
            end
            S_CPY_WR:
            begin
                tab_we = 1'b1;
                tab_waddr = IDX_W'(lo_reg + k_reg);
                tab_wdata = scr_rdata;
                k_next = k_reg + 1'b1;
            end
            S_RUN_NEXT:
            begin
                lo_next = N_W'({1'b0, lo_reg} + {w_reg, 1'b0});
            end
            S_DONE:
            begin
                done_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // A result is strobed only on the cycle after the sequencer leaves work.
    a_done_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy)) else $error("result without a request");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= N_W'(TABLE_DEPTH)) else $error("count past depth");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + 1'b1))
        else $error("count moved by other than one");
    a_idle_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done) else $error("result in accept cycle");

endmodule
`default_nettype wire

// ===== rtl/srts_store.sv =====
// Record memory and merge scratch memory for the record table.
// Depends on srts_pkg for the record struct.
`default_nettype none
module srts_store
    import srts_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int IDX_W = $clog2(TABLE_DEPTH)
)
(
    input  wire logic             clk,
    input  wire logic             tab_we,
    input  wire logic [IDX_W-1:0] tab_waddr,
    input  wire record_t          tab_wdata,
    input  wire logic [IDX_W-1:0] tab_raddr,
    output record_t               tab_rdata,
    input  wire logic             scr_we,
    input  wire logic [IDX_W-1:0] scr_waddr,
    input  wire record_t          scr_wdata,
    input  wire logic [IDX_W-1:0] scr_raddr,
    output record_t               scr_rdata
);

    record_t table_mem [TABLE_DEPTH];
    record_t scratch_mem [TABLE_DEPTH];

    // Table: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            table_mem[tab_waddr] <= tab_wdata;
        end
        tab_rdata <= table_mem[tab_raddr];
    end

    // Scratch holds one merged run before it is copied back.
    always_ff @(posedge clk)
    begin
        if (scr_we)
        begin
            scratch_mem[scr_waddr] <= scr_wdata;
        end
        scr_rdata <= scratch_mem[scr_raddr];
    end

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for sorted_record_table_search: directed and random
// append, sort, find and read requests checked against an in-bench predictor.
// Depends on srts_pkg and the sorted_record_table_search RTL.
`timescale 1ns / 1ps

import srts_pkg::*;

// Scoreboard: mirrors the record table and queues the expected result of
// every accepted request.
class record_table_scoreboard;
    localparam int DEPTH = DEFAULT_TABLE_DEPTH;

    record_t  rows[DEPTH];
    int       row_count;
    result_t  expected_results[$];
    int       mismatches;
    int       checked;

    function new();
        row_count  = 0;
        mismatches = 0;
        checked    = 0;
    endfunction

    // Bottom-up stable merge sort over the held rows; ties keep the left run.
    function void sort_rows();
        record_t merged[$];
        int w, lo, mid, hi, i, j;
        for (w = 1; w < row_count; w = w * 2)
        begin
            for (lo = 0; lo + w < row_count; lo = lo + 2 * w)
            begin
                mid = lo + w;
                hi  = (mid + w < row_count) ? mid + w : row_count;
                merged.delete();
                i = lo;
                j = mid;
                while (i < mid || j < hi)
                begin
                    if (j >= hi || (i < mid && rows[i].key <= rows[j].key))
                    begin
                        merged.push_back(rows[i]);
                        i++;
                    end
                    else
                    begin
                        merged.push_back(rows[j]);
                        j++;
                    end
                end
                for (i = 0; i < merged.size(); i++)
                    rows[lo + i] = merged[i];
            end
        end
    endfunction

    // Halving search; returns -1 when the key is not met.
    function int halving_search(logic [KEY_W-1:0] sought);
        int l, r, m;
        l = 0;
        r = row_count - 1;
        while (l <= r)
        begin
            m = (l + r) / 2;
            if (rows[m].key == sought)
                return m;
            if (rows[m].key < sought)
                l = m + 1;
            else
                r = m - 1;
        end
        return -1;
    endfunction

    function void fill_row(ref result_t e, input int pos);
        e.found_position = pos[POS_W-1:0];
        e.out_key        = rows[pos].key;
        e.out_prev       = rows[pos].prev_word;
        e.out_next       = rows[pos].next_word;
    endfunction

    // Note an accepted request and queue the result it must produce.
    function void note_request(request_t rq);
        result_t e;
        int hit;
        e = '0;
        case (command_t'(rq.command))
            CMD_APPEND:
            begin
                if (row_count >= DEPTH)
                    e.status = ST_FULL;
                else
                begin
                    rows[row_count] = '{rq.key, rq.prev_word, rq.next_word};
                    fill_row(e, row_count);
                    row_count++;
                end
            end
            CMD_SORT:
                sort_rows();
            CMD_FIND:
            begin
                hit = halving_search(rq.key);
                if (hit < 0)
                    e.status = ST_NOT_FOUND;
                else
                    fill_row(e, hit);
            end
            default:
            begin
                if (int'(rq.position) >= row_count)
                    e.status = ST_RANGE;
                else
                    fill_row(e, int'(rq.position));
            end
        endcase
        e.entry_count = row_count[CNT_W-1:0];
        expected_results.push_back(e);
    endfunction

    // Compare one result with the oldest expectation.
    function void check_result(result_t got);
        result_t e;
        if (expected_results.size() == 0)
        begin
            $error("result with no request outstanding: %h", got);
            mismatches++;
            return;
        end
        e = expected_results.pop_front();
        checked++;
        if (got.status !== e.status)
        begin
            $error("status: expected %0d, actual %0d", e.status, got.status);
            mismatches++;
        end
        if (got.found_position !== e.found_position)
        begin
            $error("found_position: expected %0d, actual %0d",
                   e.found_position, got.found_position);
            mismatches++;
        end
        if (got.entry_count !== e.entry_count)
        begin
            $error("entry_count: expected %0d, actual %0d", e.entry_count, got.entry_count);
            mismatches++;
        end
        if (got.out_key !== e.out_key)
        begin
            $error("out_key: expected %h, actual %h", e.out_key, got.out_key);
            mismatches++;
        end
        if (got.out_prev !== e.out_prev)
        begin
            $error("out_prev: expected %h, actual %h", e.out_prev, got.out_prev);
            mismatches++;
        end
        if (got.out_next !== e.out_next)
        begin
            $error("out_next: expected %h, actual %h", e.out_next, got.out_next);
            mismatches++;
        end
    endfunction
endclass

module tb;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int SETTLE_CYCLES  = 50;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    request_t request;
    logic     done;
    result_t  result;

    record_table_scoreboard table_sb;
    int idle_pct;
    int stall_cycles;
    int cmd_seen[4];

    sorted_record_table_search u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    // Clock: 8 ns period.
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Result monitor: every strobed result is checked at the edge that ends it.
    always @(posedge clk)
    begin
        if (rst_n && done)
            table_sb.check_result(result);
    end

    // Watchdog: counts cycles in which neither a request nor a result moves.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [KEY_W-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // Send one request, idling first at random, and wait for its acceptance.
    task automatic send_request(request_t rq);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start   <= 1'b1;
        request <= rq;
        do
            @(posedge clk);
        while (busy);
        table_sb.note_request(rq);
        cmd_seen[rq.command]++;
    endtask

    task automatic send_cmd(command_t cmd, logic [KEY_W-1:0] key,
                            logic [KEY_W-1:0] pw, logic [KEY_W-1:0] nw,
                            logic [POS_W-1:0] pos);
        request_t rq;
        rq.command   = cmd;
        rq.key       = key;
        rq.prev_word = pw;
        rq.next_word = nw;
        rq.position  = pos;
        send_request(rq);
    endtask

    // Hold off until every expected result has come, then let the block settle.
    task automatic drain();
        start <= 1'b0;
        while (table_sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One random request, mostly meaningful: keys often from the table or a
    // small pool so that duplicates and hits are common.
    task automatic random_request();
        int pick;
        int n;
        logic [KEY_W-1:0] key;
        logic [POS_W-1:0] pos;
        command_t cmd;
        pick = $urandom_range(99);
        n    = table_sb.row_count;
        case ($urandom_range(3))
            0: key = rand_word();
            1: key = KEY_W'($urandom_range(15));
            default:
                key = (n > 0) ? table_sb.rows[$urandom_range(n - 1)].key : rand_word();
        endcase
        if (n > 0 && $urandom_range(3) != 0)
            pos = POS_W'($urandom_range(n - 1));
        else
            pos = POS_W'($urandom_range(1023));
        if (pick < 40)
            cmd = CMD_APPEND;
        else if (pick < 45)
            cmd = CMD_SORT;
        else if (pick < 78)
            cmd = CMD_FIND;
        else
            cmd = CMD_READ;
        send_cmd(cmd, key, rand_word(), rand_word(), pos);
    endtask

    initial
    begin
        table_sb     = new();
        rst_n        = 1'b0;
        start        = 1'b0;
        request      = '0;
        idle_pct     = 16;
        stall_cycles = 0;
        cmd_seen     = '{default: 0};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, extremes, duplicates, unsorted and sorted search.
        send_cmd(CMD_FIND, '0, '0, '0, '0);
        send_cmd(CMD_READ, '0, '0, '0, '0);
        send_cmd(CMD_SORT, '0, '0, '0, '0);
        send_cmd(CMD_APPEND, '1, '0, '1, '0);
        send_cmd(CMD_APPEND, 64'd5, 64'd1, 64'd2, '1);
        send_cmd(CMD_APPEND, '0, '1, '0, '0);
        send_cmd(CMD_APPEND, 64'd5, 64'd3, 64'd4, '0);
        send_cmd(CMD_APPEND, 64'd3, rand_word(), rand_word(), '0);
        send_cmd(CMD_APPEND, 64'd5, 64'd5, 64'd6, '0);
        send_cmd(CMD_FIND, 64'd5, '0, '0, '0);
        send_cmd(CMD_FIND, '1, '0, '0, '0);
        send_cmd(CMD_READ, '0, '0, '0, 10'd5);
        send_cmd(CMD_READ, '0, '0, '0, 10'd6);
        send_cmd(CMD_READ, '0, '0, '0, '1);
        send_cmd(CMD_SORT, '0, '0, '0, '0);
        send_cmd(CMD_READ, '0, '0, '0, 10'd0);
        send_cmd(CMD_READ, '0, '0, '0, 10'd2);
        send_cmd(CMD_READ, '0, '0, '0, 10'd4);
        send_cmd(CMD_FIND, 64'd5, '0, '0, '0);
        send_cmd(CMD_FIND, '0, '0, '0, '0);
        send_cmd(CMD_FIND, '1, '0, '0, '0);
        send_cmd(CMD_FIND, 64'd4, '0, '0, '0);
        drain();

        // Random: three idling phases on the sender side.
        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 16 : (phase == 1) ? 83 : 0;
            for (int i = 0; i < 150; i++)
                random_request();
            drain();
        end

        // Sort the grown table once more, then probe it.
        idle_pct = 5;
        send_cmd(CMD_SORT, '0, '0, '0, '0);
        send_cmd(CMD_READ, '0, '0, '0, '1);
        for (int i = 0; i < 20; i++)
            random_request();
        drain();

        $display("Covered %0d appends, %0d sorts, %0d finds and %0d reads; %0d results checked.",
                 cmd_seen[CMD_APPEND], cmd_seen[CMD_SORT], cmd_seen[CMD_FIND],
                 cmd_seen[CMD_READ], table_sb.checked);
        $display("Searches and reads ran on both unsorted and freshly sorted tables.");
        if (table_sb.mismatches == 0 && table_sb.expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
